// ===== hw/rtl/adcmad_pkg.sv =====
// Shared types and constants of the converter moving-average / dead-band unit.
`default_nettype none

package adcmad_pkg;

  // Field widths fixed by the item format
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VAL_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned VAL_MAX   = (2 ** VAL_W) - 1;

  // Sample value assembly masks
  localparam logic [VAL_W-1:0] VALUE_HIGH_MASK = 10'h300;
  localparam logic [VAL_W-1:0] VALUE_LOW_MASK  = 10'h0FF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 2'd2;

  // Register reset values
  localparam logic [VAL_W-1:0] DEAD_BAND_RST = 10'd4;
  localparam logic [VAL_W-1:0] MIN_VALUE_RST = 10'd0;
  localparam logic [VAL_W-1:0] MAX_VALUE_RST = 10'd1023;

  // Request kind codes on the input channel
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLAG   = 1'b1;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified request kind
  typedef enum logic [1:0] {
    ITEM_SAMPLE = 2'd0,
    ITEM_FLAG   = 2'd1,
    ITEM_SKIP   = 2'd2
  } item_kind_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  sample;
    logic              flag;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] dead_band;
    logic [VAL_W-1:0] clamp_lo;
    logic [VAL_W-1:0] clamp_hi;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_out;
    logic [VAL_W-1:0]  reported_value;
    logic              updated_flag;
    logic              changed_now;
  } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/adcmad_if.sv =====
// Request and response channel interfaces of the moving-average / dead-band unit.
`default_nettype none

interface adcmad_req_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [adcmad_pkg::CHAN_W-1:0]   channel;
  logic [adcmad_pkg::BYTE_W-1:0]   rx_high;
  logic [adcmad_pkg::BYTE_W-1:0]   rx_low;
  logic                            flag_value;

  modport source (output valid, kind, channel, rx_high, rx_low, flag_value, input ready);
  modport sink   (input valid, kind, channel, rx_high, rx_low, flag_value, output ready);
endinterface

interface adcmad_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [adcmad_pkg::CHAN_W-1:0]  channel_out;
  logic [adcmad_pkg::VAL_W-1:0]   reported_value;
  logic                           updated_flag;
  logic                           changed_now;

  modport source (output valid, channel_out, reported_value, updated_flag, changed_now,
                  input ready);
  modport sink   (input valid, channel_out, reported_value, updated_flag, changed_now,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adc_moving_average_deadband_unit.sv =====
// Top level of the converter moving-average / dead-band unit.
// Requests arrive on req_i (valid/ready): a sample request carries a channel and
// the two received bytes, a flag request writes that channel's updated flag.
// Every request yields exactly one response on rsp_o (valid/ready) with the
// channel, its reported value, its updated flag and whether this sample
// replaced the reported value. Responses leave in request order.
// The front registers and classifies a request, a two-entry queue decouples it
// from the back, which works one request at a time.
// A sample request passes the back through S_REC, S_WIN, S_SUM, S_DIV and S_CMP
// to S_OUT, waiting in S_DIV on the bit-serial divider of the window sum by the
// fill count, one quotient bit per cycle. Flag requests pass S_REC and S_WIN to
// S_OUT; requests for channels past CHANNELS go from S_IDLE straight to S_OUT.
// Reset clears all channel state and loads the register defaults (dead band 4,
// min 0, max 1023). Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user must write them only while the block is idle; the block itself does
// not enforce this. A stalled receiver holds the response register; the queue
// then fills and req_i.ready drops.
`default_nettype none

module adc_moving_average_deadband_unit #(
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  adcmad_req_if.sink                               req_i,
  adcmad_rsp_if.source                             rsp_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [adcmad_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [adcmad_pkg::VAL_W-1:0]        cfg_wdata_i
);

  adcmad_pkg::cfg_t  cfg_q;
  adcmad_pkg::item_t push_item, pop_item;
  logic              push_valid, push_ready, pop_valid, pop_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dead_band <= adcmad_pkg::DEAD_BAND_RST;
      cfg_q.clamp_lo  <= adcmad_pkg::MIN_VALUE_RST;
      cfg_q.clamp_hi  <= adcmad_pkg::MAX_VALUE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adcmad_pkg::CFG_DEAD_BAND: cfg_q.dead_band <= cfg_wdata_i;
        adcmad_pkg::CFG_MIN_VALUE: cfg_q.clamp_lo  <= cfg_wdata_i;
        adcmad_pkg::CFG_MAX_VALUE: cfg_q.clamp_hi  <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  adcmad_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  adcmad_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  adcmad_back #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_item_i  (pop_item),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/adcmad_front.sv =====
// Front stage: accepts requests, assembles the sample and classifies the request.
`default_nettype none

module adcmad_front #(
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  adcmad_req_if.sink         req_i,
  output adcmad_pkg::item_t  push_item_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);

  localparam int unsigned CMP_W = 7;

  logic              hold_valid_q, hold_valid_d;
  adcmad_pkg::item_t hold_q, item_c;
  logic              accept;
  logic [adcmad_pkg::VAL_W-1:0] sample_c;

  // Take a new request whenever the holding register is empty or empties this cycle
  assign req_i.ready = !hold_valid_q || push_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  // Assemble the 10-bit value from the two bytes
  assign sample_c = ((adcmad_pkg::VAL_W'(req_i.rx_high) << 8) & adcmad_pkg::VALUE_HIGH_MASK)
                  | (adcmad_pkg::VAL_W'(req_i.rx_low) & adcmad_pkg::VALUE_LOW_MASK);

  // Classify: channels past the configured count are answered without state
  always_comb begin
    item_c.channel = req_i.channel;
    item_c.sample  = sample_c;
    item_c.flag    = req_i.flag_value;
    if (CMP_W'(req_i.channel) >= CMP_W'(CHANNELS)) begin
      item_c.kind = adcmad_pkg::ITEM_SKIP;
    end else if (req_i.kind == adcmad_pkg::KIND_FLAG) begin
      item_c.kind = adcmad_pkg::ITEM_FLAG;
    end else begin
      item_c.kind = adcmad_pkg::ITEM_SAMPLE;
    end
  end

  assign hold_valid_d = accept || (hold_valid_q && !push_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= item_c;
    end
  end

  assign push_valid_o = hold_valid_q;
  assign push_item_o  = hold_q;

endmodule

`default_nettype wire

// ===== hw/rtl/adcmad_queue.sv =====
// Short FIFO of classified requests between the front and back stages.
`default_nettype none

module adcmad_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire adcmad_pkg::item_t  push_item_i,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  output adcmad_pkg::item_t       pop_item_o,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i
);

  localparam int unsigned DEPTH = adcmad_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  adcmad_pkg::item_t  mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Fill count stays in range
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  // A full queue keeps its entries until a pop
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_W'(DEPTH)) && !pop |=> count_q == CNT_W'(DEPTH))
    else $error("queue lost an entry while full");

  // Count rises by one on a push without a pop
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

// ===== hw/rtl/adcmad_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module adcmad_div #(
  parameter int unsigned NUM_W = 14,
  parameter int unsigned DEN_W = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  nq_q;
  logic [DEN_W-1:0]  rem_q, den_q, rem_nx;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  // One trial subtraction
  assign rem_sh = {rem_q, nq_q[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_nx = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : DEN_W'(rem_sh);

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= STEP_W'(step_q + 1'b1);
        if (step_q == STEP_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      nq_q  <= {nq_q[NUM_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

`default_nettype wire

// ===== hw/rtl/adcmad_back.sv =====
// Back stage: per-channel window update, mean, clamp, dead band and result register.
`default_nettype none

module adcmad_back #(
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire adcmad_pkg::cfg_t   cfg_i,
  input  wire adcmad_pkg::item_t  pop_item_i,
  input  wire logic               pop_valid_i,
  output logic                    pop_ready_o,
  adcmad_rsp_if.source            rsp_o
);

  localparam int unsigned VAL_W  = adcmad_pkg::VAL_W;
  localparam int unsigned PW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW * adcmad_pkg::VAL_MAX + 1);
  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOTS  = CHANNELS * WINDOW;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W  = 7;

  typedef struct packed {
    logic [PW-1:0]    pos;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] fill;
    logic [VAL_W-1:0] last;
    logic             flag;
  } rec_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_REC  = 7'b0000010,
    S_WIN  = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  adcmad_pkg::item_t item_q;
  rec_t              rec_mem [CHANNELS];
  rec_t              rec_raw_q, rec_rd, rec_l_q, nrec_q, rec_wdata;
  logic [CHANNELS-1:0] vld_q;
  logic              rec_hit_q, rec_we;
  logic [VAL_W-1:0]  win_mem [SLOTS];
  logic [VAL_W-1:0]  win_rdata_q;
  logic              win_we;
  logic [SLOT_W-1:0] slot_c, slot_q;
  logic [CH_W-1:0]   ch_idx;
  adcmad_pkg::rsp_t  res_q, res_d, out_q;
  logic              out_valid_q, out_load;

  // Window update signals
  logic              full;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  fill_new;
  logic [PW-1:0]     pos_new;

  // Mean and dead band signals
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [VAL_W-1:0]  mean, v;
  logic              near_lo, near_up, at_bound, upd;

  assign ch_idx = CH_W'(item_q.channel);
  assign rec_rd = rec_hit_q ? rec_raw_q : '0;
  assign slot_c = SLOT_W'(SLOT_W'(ch_idx) * SLOT_W'(WINDOW)) + SLOT_W'(rec_rd.pos);

  // Channel record memory, registered read
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[ch_idx] <= rec_wdata;
    end
    rec_raw_q <= rec_mem[ch_idx];
  end

  // Per-channel valid bits: an unwritten record reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rec_hit_q <= 1'b0;
    end else begin
      if (rec_we) begin
        vld_q[ch_idx] <= 1'b1;
      end
      rec_hit_q <= vld_q[ch_idx];
    end
  end

  // Window sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[slot_q] <= item_q.sample;
    end
    win_rdata_q <= win_mem[slot_c];
  end

  // Ring update: drop the oldest entry once the window is full
  assign full     = (rec_l_q.fill == CNT_W'(WINDOW));
  assign sum_new  = SUM_W'(rec_l_q.sum - (full ? SUM_W'(win_rdata_q) : '0))
                  + SUM_W'(item_q.sample);
  assign fill_new = full ? rec_l_q.fill : CNT_W'(rec_l_q.fill + 1'b1);
  assign pos_new  = (rec_l_q.pos == PW'(WINDOW - 1)) ? '0 : PW'(rec_l_q.pos + 1'b1);
  assign win_we   = (state_q == S_SUM);

  adcmad_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_SUM),
    .num_i   (sum_new),
    .den_i   (fill_new),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Clamp, then dead band test around the last reported value
  assign mean = VAL_W'(div_quo);
  always_comb begin
    if (mean < cfg_i.clamp_lo) begin
      v = cfg_i.clamp_lo;
    end else if (mean > cfg_i.clamp_hi) begin
      v = cfg_i.clamp_hi;
    end else begin
      v = mean;
    end
  end
  assign near_lo  = ({1'b0, v} + {1'b0, cfg_i.dead_band}) <= {1'b0, nrec_q.last};
  assign near_up  = {1'b0, v} >= ({1'b0, nrec_q.last} + {1'b0, cfg_i.dead_band});
  assign at_bound = (v == cfg_i.clamp_lo) || (v == cfg_i.clamp_hi);
  assign upd      = ((v < cfg_i.clamp_hi) && (near_lo || near_up))
                 || (at_bound && (v != nrec_q.last));

  // Record write-back and result
  always_comb begin
    rec_we    = 1'b0;
    rec_wdata = nrec_q;
    res_d     = res_q;
    unique case (state_q)
      S_WIN: begin
        if (item_q.kind == adcmad_pkg::ITEM_FLAG) begin
          rec_we         = 1'b1;
          rec_wdata      = rec_rd;
          rec_wdata.flag = item_q.flag;
          res_d = '{channel_out: item_q.channel, reported_value: rec_rd.last,
                    updated_flag: item_q.flag, changed_now: 1'b0};
        end
      end
      S_CMP: begin
        rec_we         = 1'b1;
        rec_wdata.last = upd ? v : nrec_q.last;
        rec_wdata.flag = upd || nrec_q.flag;
        res_d = '{channel_out: item_q.channel, reported_value: rec_wdata.last,
                  updated_flag: rec_wdata.flag, changed_now: upd};
      end
      S_IDLE: begin
        res_d = '{channel_out: pop_item_i.channel, reported_value: '0,
                  updated_flag: 1'b0, changed_now: 1'b0};
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Sequencer
  assign pop_ready_o = (state_q == S_IDLE);
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          state_d = (pop_item_i.kind == adcmad_pkg::ITEM_SKIP) ? S_OUT : S_REC;
        end
      end
      S_REC:  state_d = S_WIN;
      S_WIN:  state_d = (item_q.kind == adcmad_pkg::ITEM_FLAG) ? S_OUT : S_SUM;
      S_SUM:  state_d = S_DIV;
      S_DIV:  state_d = div_done ? S_CMP : S_DIV;
      S_CMP:  state_d = S_OUT;
      S_OUT:  state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && !rsp_o.ready);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && pop_valid_i) begin
      item_q <= pop_item_i;
    end
    if (state_q == S_WIN) begin
      rec_l_q <= rec_rd;
      slot_q  <= slot_c;
    end
    if (state_q == S_SUM) begin
      nrec_q <= '{pos: pos_new, sum: sum_new, fill: fill_new,
                  last: rec_l_q.last, flag: rec_l_q.flag};
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.channel_out    = out_q.channel_out;
  assign rsp_o.reported_value = out_q.reported_value;
  assign rsp_o.updated_flag   = out_q.updated_flag;
  assign rsp_o.changed_now    = out_q.changed_now;

  // A fresh report always raises the channel's flag
  a_changed_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.changed_now |-> out_q.updated_flag)
    else $error("changed result without updated flag");

  // Divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside of wait state");

  // Only in-range channels can report a change
  a_changed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.changed_now |-> CMP_W'(out_q.channel_out) < CMP_W'(CHANNELS))
    else $error("change reported for unknown channel");

endmodule

`default_nettype wire
